/* hdl/jsu_pkg.sv */
// shared types, codes and helpers for the json string unescaper
package jsu_pkg;

   localparam logic [2:0] MODE_NORMAL = 3'd0;
   localparam logic [2:0] MODE_ESC    = 3'd1;
   localparam logic [2:0] MODE_HEX0   = 3'd2;
   localparam logic [2:0] MODE_HEX1   = 3'd3;
   localparam logic [2:0] MODE_HEX2   = 3'd4;
   localparam logic [2:0] MODE_HEX3   = 3'd5;

   localparam logic [1:0] ERR_OK             = 2'd0;
   localparam logic [1:0] ERR_MISSING_ESCAPE = 2'd1;
   localparam logic [1:0] ERR_INVALID_ESCAPE = 2'd2;
   localparam logic [1:0] ERR_UNTERMINATED   = 2'd3;

   localparam logic [7:0] CH_QUOTE     = 8'h22;
   localparam logic [7:0] CH_BACKSLASH = 8'h5c;
   localparam logic [7:0] CH_SLASH     = 8'h2f;
   localparam logic [7:0] CH_B         = 8'h62;
   localparam logic [7:0] CH_F         = 8'h66;
   localparam logic [7:0] CH_N         = 8'h6e;
   localparam logic [7:0] CH_R         = 8'h72;
   localparam logic [7:0] CH_T         = 8'h74;
   localparam logic [7:0] CH_U         = 8'h75;
   localparam logic [7:0] CH_SPACE     = 8'h20;

   localparam logic [7:0] BS_CODE  = 8'h08;
   localparam logic [7:0] FF_CODE  = 8'h0c;
   localparam logic [7:0] LF_CODE  = 8'h0a;
   localparam logic [7:0] CR_CODE  = 8'h0d;
   localparam logic [7:0] TAB_CODE = 8'h09;

   localparam logic [7:0] UTF8_LEAD2 = 8'hc0;
   localparam logic [7:0] UTF8_LEAD3 = 8'he0;
   localparam logic [7:0] UTF8_CONT  = 8'h80;

   typedef struct packed {
      logic [1:0]      count;
      logic [2:0][7:0] bytes;
      logic            byte_valid;
      logic            done;
      logic [1:0]      err;
   } jsu_result_type;

   // {is_hex, value}
   function automatic logic [4:0] hex_value(input logic [7:0] c);
      logic [4:0] r;
      r = 5'd0;
      if (c >= 8'h30 && c <= 8'h39) begin
         r = {1'b1, 4'(c - 8'h30)};
      end else if (c >= 8'h41 && c <= 8'h46) begin
         r = {1'b1, 4'(c - 8'h37)};
      end else if (c >= 8'h61 && c <= 8'h66) begin
         r = {1'b1, 4'(c - 8'h57)};
      end
      return r;
   endfunction

endpackage

/* hdl/json_string_unescape.sv */
// json string body unescaper top level: input register, decode, result buffer
// One source byte is taken per transaction and may be accepted every cycle while
// req_stall is low. Each byte passes an input register and combinational decode and
// lands in a three-entry result buffer; a backslash, a u and the first three hex
// digits leave no result, a plain byte, escape, closing quote or error leave one, and
// the last hex digit of \uXXXX leaves one to three utf-8 bytes. The result buffer sends
// one byte per cycle while rsp_stall is low, so a multi-byte code point holds the input
// side for its extra bytes. strict_mode resets to 1; the user is to write it through the
// csr channel only while the block is idle, and the block itself does not enforce this.
module json_string_unescape (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_in_byte,
   input  logic       req_source_end,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_byte_valid,
   output logic       rsp_string_done,
   output logic [1:0] rsp_error_code,
   output logic       rsp_run_last,
   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic       csr_strict_mode
);
   import jsu_pkg::*;

   logic            strict_ff, strict_in;
   logic [2:0]      mode_ff, mode_in;
   logic [11:0]     hex_ff, hex_in;
   logic            in_valid_ff, in_valid_in;
   logic [7:0]      in_byte_ff;
   logic            in_end_ff;
   logic [1:0]      cnt_ff, cnt_in;
   logic [2:0][7:0] bytes_ff, bytes_in;
   logic            bvalid_ff, bvalid_in;
   logic            done_ff, done_in;
   logic [1:0]      err_ff, err_in;

   logic [2:0]      dec_mode;
   logic [11:0]     dec_hex;
   jsu_result_type  dec;
   logic            pop, buf_free, in_move;

   jsu_decode u_decode (
      .mode        (mode_ff),
      .hex_accum   (hex_ff),
      .strict_mode (strict_ff),
      .in_byte     (in_byte_ff),
      .source_end  (in_end_ff),
      .mode_next   (dec_mode),
      .hex_next    (dec_hex),
      .result      (dec)
   );

   assign csr_ready = 1'b1;

   assign rsp_valid = (cnt_ff != 2'd0);
   assign pop = rsp_valid && !rsp_stall;
   assign buf_free = (cnt_ff == 2'd0) || (cnt_ff == 2'd1 && !rsp_stall);
   assign in_move = in_valid_ff && buf_free;
   assign req_stall = in_valid_ff && !buf_free;

   assign rsp_out_byte = bvalid_ff ? bytes_ff[0] : 8'h00;
   assign rsp_byte_valid = bvalid_ff;
   assign rsp_string_done = done_ff;
   assign rsp_error_code = err_ff;
   assign rsp_run_last = (cnt_ff == 2'd1);

   always_comb begin
      strict_in = (csr_valid && csr_ready) ? csr_strict_mode : strict_ff;
      mode_in = in_move ? dec_mode : mode_ff;
      hex_in = in_move ? dec_hex : hex_ff;
      in_valid_in = req_valid ? 1'b1 : (in_valid_ff && !in_move);

      cnt_in = cnt_ff;
      bytes_in = bytes_ff;
      bvalid_in = bvalid_ff;
      done_in = done_ff;
      err_in = err_ff;
      if (pop) begin
         cnt_in = cnt_ff - 2'd1;
         bytes_in = {8'h00, bytes_ff[2], bytes_ff[1]};
      end
      if (in_move) begin
         cnt_in = dec.count;
         bytes_in = dec.bytes;
         bvalid_in = dec.byte_valid;
         done_in = dec.done;
         err_in = dec.err;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         strict_ff <= 1'b1;
         mode_ff <= MODE_NORMAL;
         hex_ff <= '0;
         in_valid_ff <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         strict_ff <= strict_in;
         mode_ff <= mode_in;
         hex_ff <= hex_in;
         in_valid_ff <= in_valid_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         in_byte_ff <= req_in_byte;
         in_end_ff <= req_source_end;
      end
      bytes_ff <= bytes_in;
      bvalid_ff <= bvalid_in;
      done_ff <= done_in;
      err_ff <= err_in;
   end

   // string end is a single non-data transaction
   a_done_alone: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_string_done |-> rsp_run_last && !rsp_byte_valid)
      else $error("string end not a lone last transaction");

   a_err_ends: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_error_code != ERR_OK |-> rsp_string_done)
      else $error("error without string end");

   // later bytes of a multi-byte code point follow directly
   a_utf8_cont: assert property (@(posedge clock) disable iff (reset)
      pop && !rsp_run_last |=> rsp_valid && rsp_byte_valid)
      else $error("multi-byte sequence broken");

   a_end_clears: assert property (@(posedge clock) disable iff (reset)
      in_move && dec.done |=> mode_ff == MODE_NORMAL && hex_ff == 12'h000)
      else $error("decode state not cleared at string end");

endmodule

/* hdl/jsu_decode.sv */
// per-byte decode of escape mode, hex gathering and utf-8 encoding
module jsu_decode (
   input  logic [2:0]             mode,
   input  logic [11:0]            hex_accum,
   input  logic                   strict_mode,
   input  logic [7:0]             in_byte,
   input  logic                   source_end,
   output logic [2:0]             mode_next,
   output logic [11:0]            hex_next,
   output jsu_pkg::jsu_result_type result
);
   import jsu_pkg::*;

   logic [4:0]  hv;
   logic [15:0] uc;

   assign hv = hex_value(in_byte);
   assign uc = {hex_accum, hv[3:0]};

   always_comb begin
      mode_next = mode;
      hex_next = hex_accum;
      result.count = 2'd0;
      result.bytes = '0;
      result.byte_valid = 1'b0;
      result.done = 1'b0;
      result.err = ERR_OK;

      if (source_end) begin
         mode_next = MODE_NORMAL;
         hex_next = '0;
         result.count = 2'd1;
         result.done = 1'b1;
         result.err = ERR_UNTERMINATED;
      end else begin
         case (mode)
            MODE_ESC: begin
               mode_next = MODE_NORMAL;
               result.count = 2'd1;
               result.byte_valid = 1'b1;
               case (in_byte)
                  CH_QUOTE, CH_BACKSLASH, CH_SLASH: result.bytes[0] = in_byte;
                  CH_B: result.bytes[0] = BS_CODE;
                  CH_F: result.bytes[0] = FF_CODE;
                  CH_N: result.bytes[0] = LF_CODE;
                  CH_R: result.bytes[0] = CR_CODE;
                  CH_T: result.bytes[0] = TAB_CODE;
                  CH_U: begin
                     mode_next = MODE_HEX0;
                     hex_next = '0;
                     result.count = 2'd0;
                     result.byte_valid = 1'b0;
                  end
                  default: begin
                     hex_next = '0;
                     result.byte_valid = 1'b0;
                     result.done = 1'b1;
                     result.err = ERR_INVALID_ESCAPE;
                  end
               endcase
            end
            MODE_HEX0, MODE_HEX1, MODE_HEX2, MODE_HEX3: begin
               if (!hv[4]) begin
                  mode_next = MODE_NORMAL;
                  hex_next = '0;
                  result.count = 2'd1;
                  result.done = 1'b1;
                  result.err = ERR_INVALID_ESCAPE;
               end else if (mode != MODE_HEX3) begin
                  mode_next = mode + 3'd1;
                  hex_next = uc[11:0];
               end else begin
                  mode_next = MODE_NORMAL;
                  hex_next = '0;
                  result.byte_valid = 1'b1;
                  if (uc[15:7] == '0) begin
                     result.count = 2'd1;
                     result.bytes[0] = uc[7:0];
                  end else if (uc[15:11] == '0) begin
                     result.count = 2'd2;
                     result.bytes[0] = UTF8_LEAD2 | {3'b000, uc[10:6]};
                     result.bytes[1] = UTF8_CONT | {2'b00, uc[5:0]};
                  end else begin
                     result.count = 2'd3;
                     result.bytes[0] = UTF8_LEAD3 | {4'h0, uc[15:12]};
                     result.bytes[1] = UTF8_CONT | {2'b00, uc[11:6]};
                     result.bytes[2] = UTF8_CONT | {2'b00, uc[5:0]};
                  end
               end
            end
            default: begin
               mode_next = MODE_NORMAL;
               result.count = 2'd1;
               if (in_byte == CH_QUOTE) begin
                  hex_next = '0;
                  result.done = 1'b1;
               end else if (in_byte == CH_BACKSLASH) begin
                  mode_next = MODE_ESC;
                  result.count = 2'd0;
               end else if (strict_mode && in_byte < CH_SPACE) begin
                  hex_next = '0;
                  result.done = 1'b1;
                  result.err = ERR_MISSING_ESCAPE;
               end else begin
                  result.byte_valid = 1'b1;
                  result.bytes[0] = in_byte;
               end
            end
         endcase
      end
   end

endmodule

/* dv/json_string_unescape_test.sv */
// self-checking testbench for the json string body unescaper
module json_string_unescape_test;
   import jsu_pkg::*;

   localparam int CYCLE_LIMIT  = 200000;
   localparam int HOLD_CYCLES  = 300;
   localparam int DRAIN_CYCLES = 6;

   localparam logic [7:0] CH_ZERO    = 8'h30;
   localparam logic [7:0] CH_UPPER_A = 8'h41;
   localparam logic [7:0] CH_LOWER_A = 8'h61;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       byte_valid;
      logic       string_done;
      logic [1:0] error_code;
      logic       run_last;
   } decoded_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_stall;
   logic [7:0] req_in_byte = 8'h00;
   logic       req_source_end = 1'b0;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   logic [7:0] rsp_out_byte;
   logic       rsp_byte_valid;
   logic       rsp_string_done;
   logic [1:0] rsp_error_code;
   logic       rsp_run_last;
   logic       csr_valid = 1'b0;
   logic       csr_ready;
   logic       csr_strict_mode = 1'b0;

   // predictor state
   logic [2:0]  dec_mode = MODE_NORMAL;
   logic [11:0] hex_acc = '0;
   logic        strict_bit = 1'b1;
   decoded_type decoded_q[$];

   int  fail_count = 0;
   int  cycle_count = 0;
   int  items_sent = 0;
   bit  gap_free = 1'b0;
   int  hold_req = 0;
   int  hold_seen = 0;
   int  hold_left = 0;
   int  stall_left = 0;
   int  run_left = 0;

   json_string_unescape DUT (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_in_byte     (req_in_byte),
      .req_source_end  (req_source_end),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_out_byte    (rsp_out_byte),
      .rsp_byte_valid  (rsp_byte_valid),
      .rsp_string_done (rsp_string_done),
      .rsp_error_code  (rsp_error_code),
      .rsp_run_last    (rsp_run_last),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_strict_mode (csr_strict_mode)
   );

   always #6 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
                  decoded_q.size());
         $display("** json_string_unescape: FAILED **");
         $finish;
      end
   end

   // receiver stalls: short random bursts, rare long ones, and requested long holds
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_req != hold_seen) begin
         hold_seen = hold_req;
         hold_left = HOLD_CYCLES;
         rsp_stall <= 1'b1;
      end else if (hold_left != 0) begin
         hold_left = hold_left - 1;
         rsp_stall <= 1'b1;
      end else begin
         if (stall_left == 0 && run_left == 0) begin
            stall_left = ($urandom_range(0, 99) < 80) ? $urandom_range(1, 3)
                                                      : $urandom_range(10, 40);
            run_left = ($urandom_range(0, 99) < 85) ? $urandom_range(0, 6)
                                                    : $urandom_range(30, 80);
         end
         if (stall_left != 0) begin
            stall_left = stall_left - 1;
            rsp_stall <= 1'b1;
         end else begin
            if (run_left != 0) run_left = run_left - 1;
            rsp_stall <= 1'b0;
         end
      end
   end

   task automatic report_mismatch(input string what, input int got, input int want);
      $display("mismatch at cycle %0d: %s got %0h want %0h", cycle_count, what, got, want);
      fail_count++;
   endtask

   // result checker
   always @(posedge clock) begin
      decoded_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (decoded_q.size() == 0) begin
            report_mismatch("unexpected result, out_byte", rsp_out_byte, 0);
         end else begin
            want = decoded_q.pop_front();
            if (rsp_out_byte !== want.out_byte)
               report_mismatch("out_byte", rsp_out_byte, want.out_byte);
            if (rsp_byte_valid !== want.byte_valid)
               report_mismatch("byte_valid", rsp_byte_valid, want.byte_valid);
            if (rsp_string_done !== want.string_done)
               report_mismatch("string_done", rsp_string_done, want.string_done);
            if (rsp_error_code !== want.error_code)
               report_mismatch("error_code", rsp_error_code, want.error_code);
            if (rsp_run_last !== want.run_last)
               report_mismatch("run_last", rsp_run_last, want.run_last);
         end
      end
   end

   function automatic void add_decoded(input logic [7:0] b, input logic valid,
                                       input logic done, input logic [1:0] err,
                                       input logic last);
      decoded_type d;
      d.out_byte    = b;
      d.byte_valid  = valid;
      d.string_done = done;
      d.error_code  = err;
      d.run_last    = last;
      decoded_q.insert(decoded_q.size(), d);
   endfunction

   function automatic void close_string(input logic [1:0] err);
      dec_mode = MODE_NORMAL;
      hex_acc  = '0;
      add_decoded(8'h00, 1'b0, 1'b1, err, 1'b1);
   endfunction

   // {is_hex, value}
   function automatic logic [4:0] hex_digit(input logic [7:0] c);
      if (c >= CH_ZERO && c <= CH_ZERO + 8'd9) return {1'b1, 4'(c - CH_ZERO)};
      if (c >= CH_UPPER_A && c <= CH_UPPER_A + 8'd5)
         return {1'b1, 4'(c - CH_UPPER_A + 8'd10)};
      if (c >= CH_LOWER_A && c <= CH_LOWER_A + 8'd5)
         return {1'b1, 4'(c - CH_LOWER_A + 8'd10)};
      return 5'd0;
   endfunction

   function automatic void emit_utf8(input logic [15:0] cp);
      if (cp[15:7] == '0) begin
         add_decoded(cp[7:0], 1'b1, 1'b0, ERR_OK, 1'b1);
      end else if (cp[15:11] == '0) begin
         add_decoded(UTF8_LEAD2 | {3'b000, cp[10:6]}, 1'b1, 1'b0, ERR_OK, 1'b0);
         add_decoded(UTF8_CONT | {2'b00, cp[5:0]}, 1'b1, 1'b0, ERR_OK, 1'b1);
      end else begin
         add_decoded(UTF8_LEAD3 | {4'b0000, cp[15:12]}, 1'b1, 1'b0, ERR_OK, 1'b0);
         add_decoded(UTF8_CONT | {2'b00, cp[11:6]}, 1'b1, 1'b0, ERR_OK, 1'b0);
         add_decoded(UTF8_CONT | {2'b00, cp[5:0]}, 1'b1, 1'b0, ERR_OK, 1'b1);
      end
   endfunction

   function automatic void unescape_byte(input logic [7:0] c, input logic src_end);
      logic [4:0]  digit;
      logic [15:0] cp;
      if (src_end) begin
         close_string(ERR_UNTERMINATED);
      end else if (dec_mode == MODE_ESC) begin
         dec_mode = MODE_NORMAL;
         case (c)
            CH_QUOTE, CH_BACKSLASH, CH_SLASH: add_decoded(c, 1'b1, 1'b0, ERR_OK, 1'b1);
            CH_B: add_decoded(BS_CODE, 1'b1, 1'b0, ERR_OK, 1'b1);
            CH_F: add_decoded(FF_CODE, 1'b1, 1'b0, ERR_OK, 1'b1);
            CH_N: add_decoded(LF_CODE, 1'b1, 1'b0, ERR_OK, 1'b1);
            CH_R: add_decoded(CR_CODE, 1'b1, 1'b0, ERR_OK, 1'b1);
            CH_T: add_decoded(TAB_CODE, 1'b1, 1'b0, ERR_OK, 1'b1);
            CH_U: begin
               dec_mode = MODE_HEX0;
               hex_acc  = '0;
            end
            default: close_string(ERR_INVALID_ESCAPE);
         endcase
      end else if (dec_mode >= MODE_HEX0 && dec_mode <= MODE_HEX3) begin
         digit = hex_digit(c);
         if (!digit[4]) begin
            close_string(ERR_INVALID_ESCAPE);
         end else begin
            cp = {hex_acc, digit[3:0]};
            if (dec_mode != MODE_HEX3) begin
               hex_acc  = cp[11:0];
               dec_mode = dec_mode + 3'd1;
            end else begin
               dec_mode = MODE_NORMAL;
               hex_acc  = '0;
               emit_utf8(cp);
            end
         end
      end else begin
         dec_mode = MODE_NORMAL;
         if (c == CH_QUOTE) close_string(ERR_OK);
         else if (c == CH_BACKSLASH) dec_mode = MODE_ESC;
         else if (strict_bit && c < CH_SPACE) close_string(ERR_MISSING_ESCAPE);
         else add_decoded(c, 1'b1, 1'b0, ERR_OK, 1'b1);
      end
   endfunction

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   // one source transaction; valid stays high when the next one follows at once
   task automatic send_item(input logic [7:0] b, input logic src_end);
      int gap;
      gap = gap_free ? 0 : pick_gap();
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_in_byte    <= b;
      req_source_end <= src_end;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      unescape_byte(b, src_end);
      items_sent++;
   endtask

   task automatic drain_block();
      req_valid <= 1'b0;
      while (decoded_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_strict(input logic value);
      drain_block();
      csr_valid       <= 1'b1;
      csr_strict_mode <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      strict_bit = value;
      csr_valid <= 1'b0;
   endtask

   function automatic logic [7:0] hex_char(input logic [3:0] n, input logic upper);
      if (n < 4'd10) return CH_ZERO + 8'(n);
      return (upper ? CH_UPPER_A : CH_LOWER_A) + 8'(n) - 8'd10;
   endfunction

   function automatic logic [7:0] plain_byte();
      logic [7:0] b;
      do b = 8'($urandom_range(32, 255));
      while (b == CH_QUOTE || b == CH_BACKSLASH);
      return b;
   endfunction

   function automatic logic [7:0] escape_letter();
      case ($urandom_range(0, 7))
         0: return CH_QUOTE;
         1: return CH_BACKSLASH;
         2: return CH_SLASH;
         3: return CH_B;
         4: return CH_F;
         5: return CH_N;
         6: return CH_R;
         default: return CH_T;
      endcase
   endfunction

   function automatic logic [15:0] random_code_point();
      case ($urandom_range(0, 2))
         0: return 16'($urandom_range(0, 127));
         1: return 16'($urandom_range(128, 2047));
         default: return 16'($urandom_range(2048, 65535));
      endcase
   endfunction

   // backslash, u and the first ndigits hex digits of cp
   task automatic send_hex_prefix(input logic [15:0] cp, input int ndigits);
      int i;
      send_item(CH_BACKSLASH, 1'b0);
      send_item(CH_U, 1'b0);
      for (i = 3; i > 3 - ndigits; i--)
         send_item(hex_char(cp[i*4 +: 4], 1'($urandom_range(0, 1))), 1'b0);
   endtask

   task automatic send_unicode(input logic [15:0] cp);
      send_hex_prefix(cp, 4);
   endtask

   task automatic test_plain_bytes();
      send_item(8'hff, 1'b0);
      send_item(8'h00, 1'b0);
      send_item(CH_SPACE, 1'b0);
      send_item(CH_QUOTE, 1'b0);
   endtask

   task automatic test_escapes();
      send_item(CH_BACKSLASH, 1'b0); send_item(CH_QUOTE, 1'b0);
      send_item(CH_BACKSLASH, 1'b0); send_item(CH_BACKSLASH, 1'b0);
      send_item(CH_BACKSLASH, 1'b0); send_item(CH_SLASH, 1'b0);
      send_item(CH_BACKSLASH, 1'b0); send_item(CH_B, 1'b0);
      send_item(CH_BACKSLASH, 1'b0); send_item(CH_F, 1'b0);
      send_item(CH_BACKSLASH, 1'b0); send_item(CH_N, 1'b0);
      send_item(CH_BACKSLASH, 1'b0); send_item(CH_R, 1'b0);
      send_item(CH_BACKSLASH, 1'b0); send_item(CH_T, 1'b0);
   endtask

   task automatic test_unicode();
      // two-byte upper bound in mixed case, then the largest code point
      send_item(CH_BACKSLASH, 1'b0);
      send_item(CH_U, 1'b0);
      send_item(hex_char(4'h0, 1'b0), 1'b0);
      send_item(hex_char(4'h7, 1'b0), 1'b0);
      send_item(hex_char(4'hf, 1'b0), 1'b0);
      send_item(hex_char(4'hf, 1'b1), 1'b0);
      send_item(CH_BACKSLASH, 1'b0);
      send_item(CH_U, 1'b0);
      send_item(hex_char(4'hf, 1'b1), 1'b0);
      send_item(hex_char(4'hf, 1'b0), 1'b0);
      send_item(hex_char(4'hf, 1'b1), 1'b0);
      send_item(hex_char(4'hf, 1'b0), 1'b0);
   endtask

   task automatic test_error_paths();
      // control byte after backslash
      send_item(CH_BACKSLASH, 1'b0);
      send_item(8'h01, 1'b0);
      // quote inside a hex escape
      send_item(CH_BACKSLASH, 1'b0);
      send_item(CH_U, 1'b0);
      send_item(CH_QUOTE, 1'b0);
      // source end right after a backslash, then in plain content
      send_item(CH_BACKSLASH, 1'b0);
      send_item(8'h00, 1'b1);
      send_item(8'hff, 1'b1);
   endtask

   task automatic test_control_passthrough();
      send_item(8'h00, 1'b0);
      send_item(8'h1f, 1'b0);
      send_item(CH_QUOTE, 1'b0);
   endtask

   task automatic test_random_strings(input int count);
      int stop_at;
      int pick;
      stop_at = items_sent + count;
      while (items_sent < stop_at) begin
         if ($urandom_range(0, 31) == 0) gap_free = ~gap_free;
         pick = $urandom_range(0, 99);
         if (pick < 35) begin
            send_item(plain_byte(), 1'b0);
         end else if (pick < 55) begin
            send_item(CH_BACKSLASH, 1'b0);
            send_item(escape_letter(), 1'b0);
         end else if (pick < 75) begin
            send_unicode(random_code_point());
         end else if (pick < 80) begin
            send_item(8'($urandom_range(0, 31)), 1'b0);
         end else if (pick < 87) begin
            send_item(CH_QUOTE, 1'b0);
         end else if (pick < 91) begin
            send_item(CH_BACKSLASH, 1'b0);
            send_item(8'($urandom_range(0, 255)), 1'b0);
         end else if (pick < 95) begin
            // broken hex escape
            send_hex_prefix(random_code_point(), $urandom_range(0, 3));
            send_item(($urandom_range(0, 1) == 0) ? CH_QUOTE : 8'($urandom_range(0, 255)),
                      1'b0);
         end else begin
            // source runs out, sometimes in the middle of an escape
            case ($urandom_range(0, 2))
               1: send_item(CH_BACKSLASH, 1'b0);
               2: send_hex_prefix(random_code_point(), $urandom_range(0, 3));
               default: ;
            endcase
            send_item(8'($urandom_range(0, 255)), 1'b1);
         end
      end
      gap_free = 1'b0;
   endtask

   // receiver holds off while the sender keeps offering plain bytes and three-byte code points
   task automatic test_backpressure();
      int i;
      gap_free = 1'b1;
      hold_req <= hold_req + 1;
      for (i = 0; i < 6; i++) begin
         send_item(plain_byte(), 1'b0);
         send_unicode(16'($urandom_range(2048, 65535)));
      end
      send_item(CH_QUOTE, 1'b0);
      gap_free = 1'b0;
   endtask

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      test_plain_bytes();
      test_escapes();
      test_unicode();
      test_error_paths();
      write_strict(1'b0);
      test_control_passthrough();
      test_random_strings(100);
      write_strict(1'b1);
      test_random_strings(100);
      write_strict(1'b0);
      test_backpressure();
      write_strict(1'b1);
      test_random_strings(20);
      drain_block();
      if (fail_count == 0) begin
         $display("** json_string_unescape: PASSED **");
      end else begin
         $display("** json_string_unescape: FAILED **");
      end
      $finish;
   end

endmodule
